// ----- src/fbot_pkg.sv -----
// Shared types and codes for the frame buffer ownership tracker.
`default_nettype none
package fbot_pkg;

	typedef enum logic [2:0] {
		OP_ACQUIRE     = 3'd0,
		OP_FILL_DONE   = 3'd1,
		OP_ABANDON     = 3'd2,
		OP_SUBMIT      = 3'd3,
		OP_DRAW_DONE   = 3'd4,
		OP_PICK_TARGET = 3'd5,
		OP_HANDED      = 3'd6,
		OP_SHUTDOWN    = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		RS_OK          = 3'd0,
		RS_BAD_INDEX   = 3'd1,
		RS_WRONG_STATE = 3'd2,
		RS_STOPPING    = 3'd3,
		RS_BUSY        = 3'd4,
		RS_SPURIOUS    = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		BS_FREE      = 2'd0,
		BS_FILLING   = 2'd1,
		BS_READY     = 2'd2,
		BS_SUBMITTED = 2'd3
	} bst_t;

	localparam logic signed [4:0] NO_INDEX = -5'sd1;

	typedef struct packed {
		status_t            status;
		logic signed [4:0]  index;
	} res_t;

endpackage
`default_nettype wire

// ----- src/fbot_core.sv -----
// Decision logic: result and next ownership state for one transaction.
`default_nettype none
module fbot_core import fbot_pkg::*; #(
	parameter int TEX_BUFFERS  = 4,
	parameter int SCAN_BUFFERS = 2,
	localparam int TIDX_W = (TEX_BUFFERS > 1) ? $clog2(TEX_BUFFERS) : 1,
	localparam int SIDX_W = (SCAN_BUFFERS > 1) ? $clog2(SCAN_BUFFERS) : 1
) (
	input  op_t                op,
	input  logic [3:0]         buf_index,
	input  logic signed [4:0]  scanout_index,
	input  bst_t               bst [TEX_BUFFERS],
	input  logic               flight_valid,
	input  logic [TIDX_W-1:0]  flight_slot,
	input  logic               pending_valid,
	input  logic [SIDX_W-1:0]  pending_slot,
	input  logic               stopping,
	output bst_t               bst_nx [TEX_BUFFERS],
	output logic               flight_valid_nx,
	output logic [TIDX_W-1:0]  flight_slot_nx,
	output logic               pending_valid_nx,
	output logic [SIDX_W-1:0]  pending_slot_nx,
	output logic               stopping_nx,
	output res_t               res
);

	logic              tex_ok;
	logic              scan_ok;
	logic [TIDX_W-1:0] tidx;
	logic [SIDX_W-1:0] sidx;
	logic              free_found;
	logic [TIDX_W-1:0] free_idx;
	logic              shown_nn;
	logic              pend_eff;
	logic              pick_found;
	logic [SIDX_W-1:0] pick_idx;

	assign tex_ok   = {1'b0, buf_index} < 5'(TEX_BUFFERS);
	assign scan_ok  = {1'b0, buf_index} < 5'(SCAN_BUFFERS);
	assign tidx     = buf_index[TIDX_W-1:0];
	assign sidx     = buf_index[SIDX_W-1:0];
	assign shown_nn = !scanout_index[4];
	assign pend_eff = pending_valid &&
		!(shown_nn && (scanout_index[3:0] == 4'(pending_slot)));

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = 0; i < TEX_BUFFERS; i++) begin
			if (!free_found && bst[i] == BS_FREE) begin
				free_found = 1'b1;
				free_idx   = TIDX_W'(i);
			end
		end
	end

	always_comb begin
		pick_found = 1'b0;
		pick_idx   = '0;
		for (int i = 0; i < SCAN_BUFFERS; i++) begin
			if (!pick_found && !(shown_nn && scanout_index[3:0] == 4'(i)) &&
			    !(pend_eff && pending_slot == SIDX_W'(i))) begin
				pick_found = 1'b1;
				pick_idx   = SIDX_W'(i);
			end
		end
	end

	always_comb begin
		bst_nx           = bst;
		flight_valid_nx  = flight_valid;
		flight_slot_nx   = flight_slot;
		pending_valid_nx = pending_valid;
		pending_slot_nx  = pending_slot;
		stopping_nx      = stopping;
		res.status       = RS_OK;
		res.index        = NO_INDEX;
		unique case (op)
			OP_ACQUIRE: begin
				if (stopping) begin
					res.status = RS_STOPPING;
				end else if (!free_found) begin
					res.status = RS_BUSY;
				end else begin
					bst_nx[free_idx] = BS_FILLING;
					res.index        = 5'(free_idx);
				end
			end
			OP_FILL_DONE: begin
				if (!tex_ok) begin
					res.status = RS_BAD_INDEX;
				end else if (bst[tidx] != BS_FILLING) begin
					res.status = RS_WRONG_STATE;
				end else begin
					bst_nx[tidx] = BS_READY;
				end
			end
			OP_ABANDON: begin
				if (!tex_ok) begin
					res.status = RS_BAD_INDEX;
				end else if (bst[tidx] == BS_SUBMITTED) begin
					res.status = RS_WRONG_STATE;
				end else begin
					bst_nx[tidx] = BS_FREE;
				end
			end
			OP_SUBMIT: begin
				if (!tex_ok) begin
					res.status = RS_BAD_INDEX;
				end else if (stopping) begin
					res.status = RS_STOPPING;
				end else if (bst[tidx] != BS_READY) begin
					res.status = RS_WRONG_STATE;
				end else if (flight_valid) begin
					res.status = RS_BUSY;
				end else begin
					bst_nx[tidx]    = BS_SUBMITTED;
					flight_valid_nx = 1'b1;
					flight_slot_nx  = tidx;
				end
			end
			OP_DRAW_DONE: begin
				if (!flight_valid) begin
					res.status = RS_SPURIOUS;
				end else begin
					bst_nx[flight_slot] = BS_FREE;
					flight_valid_nx     = 1'b0;
					res.index           = 5'(flight_slot);
				end
			end
			OP_PICK_TARGET: begin
				if (stopping) begin
					res.status = RS_STOPPING;
				end else begin
					pending_valid_nx = pend_eff;
					if (!pick_found) begin
						res.status = RS_BUSY;
					end else begin
						res.index = 5'(pick_idx);
					end
				end
			end
			OP_HANDED: begin
				if (!scan_ok) begin
					res.status = RS_BAD_INDEX;
				end else begin
					pending_valid_nx = 1'b1;
					pending_slot_nx  = sidx;
				end
			end
			OP_SHUTDOWN: begin
				stopping_nx = 1'b1;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- src/frame_buffer_ownership_tracker.sv -----
// Top level: input register, ownership state and result register.
//
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------------
//  in      | in_valid, in_stall | op, buf_index, scanout_index
//  out     | out_valid,out_stall| status, result_index, token_in_flight
//
// One transaction per cycle while the result is not stalled.
// The input register and the result register bound the single decision pass.
// Reset clears all buffers to free and drops both channels' valid.
// A stalled result holds the input register; the input stalls only then.
`default_nettype none
module frame_buffer_ownership_tracker import fbot_pkg::*; #(
	parameter int TEX_BUFFERS  = 4,
	parameter int SCAN_BUFFERS = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         op,
	input  logic [3:0]         buf_index,
	input  logic signed [4:0]  scanout_index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic signed [4:0]  result_index,
	output logic               token_in_flight
);

	localparam int TIDX_W = (TEX_BUFFERS > 1) ? $clog2(TEX_BUFFERS) : 1;
	localparam int SIDX_W = (SCAN_BUFFERS > 1) ? $clog2(SCAN_BUFFERS) : 1;

	logic              valid_s1;
	op_t               op_s1;
	logic [3:0]        idx_s1;
	logic signed [4:0] shown_s1;

	bst_t              bst_q [TEX_BUFFERS];
	logic              flight_valid_q;
	logic [TIDX_W-1:0] flight_slot_q;
	logic              pending_valid_q;
	logic [SIDX_W-1:0] pending_slot_q;
	logic              stopping_q;

	bst_t              bst_nx [TEX_BUFFERS];
	logic              flight_valid_nx;
	logic [TIDX_W-1:0] flight_slot_nx;
	logic              pending_valid_nx;
	logic [SIDX_W-1:0] pending_slot_nx;
	logic              stopping_nx;
	res_t              res;

	logic              out_valid_q;
	status_t           status_q;
	logic signed [4:0] index_q;
	logic              token_q;

	logic              advance;
	logic              accept;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= op_t'(op);
			idx_s1   <= buf_index;
			shown_s1 <= scanout_index;
		end
	end

	fbot_core #(
		.TEX_BUFFERS  (TEX_BUFFERS),
		.SCAN_BUFFERS (SCAN_BUFFERS)
	) u_core (
		.op               (op_s1),
		.buf_index        (idx_s1),
		.scanout_index    (shown_s1),
		.bst              (bst_q),
		.flight_valid     (flight_valid_q),
		.flight_slot      (flight_slot_q),
		.pending_valid    (pending_valid_q),
		.pending_slot     (pending_slot_q),
		.stopping         (stopping_q),
		.bst_nx           (bst_nx),
		.flight_valid_nx  (flight_valid_nx),
		.flight_slot_nx   (flight_slot_nx),
		.pending_valid_nx (pending_valid_nx),
		.pending_slot_nx  (pending_slot_nx),
		.stopping_nx      (stopping_nx),
		.res              (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TEX_BUFFERS; i++) begin
				bst_q[i] <= BS_FREE;
			end
			flight_valid_q  <= 1'b0;
			flight_slot_q   <= '0;
			pending_valid_q <= 1'b0;
			pending_slot_q  <= '0;
			stopping_q      <= 1'b0;
		end else if (advance) begin
			bst_q           <= bst_nx;
			flight_valid_q  <= flight_valid_nx;
			flight_slot_q   <= flight_slot_nx;
			pending_valid_q <= pending_valid_nx;
			pending_slot_q  <= pending_slot_nx;
			stopping_q      <= stopping_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= res.status;
			index_q  <= res.index;
			token_q  <= flight_valid_nx;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign result_index    = index_q;
	assign token_in_flight = token_q;

endmodule
`default_nettype wire

// ----- src/fbot_checker.sv -----
// Port-level checks for the frame buffer ownership tracker, with bind.
`default_nettype none
module fbot_checker import fbot_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [2:0]         status,
	input logic signed [4:0]  result_index,
	input logic               token_in_flight
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) &&
		$stable(result_index) && $stable(token_in_flight))
		else $error("stalled result changed");

	a_index_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_index != NO_INDEX |-> status == RS_OK)
		else $error("index returned with a refusal");

	a_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == RS_SPURIOUS |-> !token_in_flight)
		else $error("spurious draw done with token in flight");

endmodule

bind frame_buffer_ownership_tracker fbot_checker u_fbot_checker (.*);
`default_nettype wire
